// ----- rtl/ntc7s_pkg.sv -----
package ntc7s_pkg;

    // Segment word: right digit in the low byte, left digit in the high byte
    localparam int WORD_BITS = 16;
    localparam int CNT_W     = $clog2(WORD_BITS);

    // Temperature 0..99 and the search over the 99 switching points
    localparam int TEMP_W    = 7;
    localparam int TAB_DEPTH = 1 << TEMP_W;
    localparam int TEMP_MAX  = 99;

    // Beta equation in hundredths of a kelvin, exponent in Q28
    localparam int QBITS     = 28;
    localparam int BETA_X100 = 395000;
    localparam int T0_X100   = 29815;
    localparam int TK_BASE   = 27265;

    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [TEMP_W-1:0]    temp_t;
    typedef logic [3:0]           digit_t;
    typedef logic [7:0]           seg_t;
    typedef logic [CNT_W-1:0]     bit_cnt_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Left display position, active low
    function automatic seg_t seg_tens(input digit_t d);
        seg_t s;
        unique case (d)
            4'd0:    s = 8'h81;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'h43;
            4'd3:    s = 8'h61;
            4'd4:    s = 8'h39;
            4'd5:    s = 8'h25;
            4'd6:    s = 8'h05;
            4'd7:    s = 8'hF1;
            4'd8:    s = 8'h01;
            4'd9:    s = 8'h21;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

    // Right display position, wired with a different segment order
    function automatic seg_t seg_units(input digit_t d);
        seg_t s;
        unique case (d)
            4'd0:    s = 8'h18;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'h2C;
            4'd3:    s = 8'h68;
            4'd4:    s = 8'hC9;
            4'd5:    s = 8'h4A;
            4'd6:    s = 8'h0A;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h08;
            4'd9:    s = 8'h48;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/ntc_temperature_to_seven_segment.sv -----
// Turns one ADC code from an NTC divider into the 16-bit word for a two-digit
// active-low seven-segment display (0..99 C, Beta 3950, saturating at both ends)
// and shifts it out one bit per transfer, least significant bit first, with
// latch_after set on the sixteenth bit. A code passes a seven-stage search over
// the per-degree switching points; its word is written into the output queue
// from the last stage register and then loaded into the shift register before
// its first bit goes out. The serial output stage sets the sustained rate:
// sixteen result bits per code, back to back while out_ready is high. Codes are
// taken every cycle while the two-word queue and the search pipe still have room.
module ntc_temperature_to_seven_segment
    import ntc7s_pkg::*;
#(
    parameter int ADC_BITS = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ADC_BITS-1:0] adc_code,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                serial_bit,
    output logic                latch_after
);

    logic    q_push;
    word_t   q_push_word;
    logic    q_pop;
    word_t   q_pop_word;
    q_stat_t q_stat;

    ntc7s_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .adc_code  (adc_code),
        .push      (q_push),
        .push_word (q_push_word),
        .stat      (q_stat)
    );

    ntc7s_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_push_word),
        .pop       (q_pop),
        .pop_word  (q_pop_word),
        .stat      (q_stat)
    );

    ntc7s_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .stat        (q_stat),
        .pop_word    (q_pop_word),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .serial_bit  (serial_bit),
        .latch_after (latch_after)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("word pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("word popped from an empty queue");

    a_latch_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && latch_after |=> !latch_after)
        else $error("latch marker on two bits in a row");

endmodule

// ----- rtl/ntc7s_front.sv -----
module ntc7s_front
    import ntc7s_pkg::*;
#(
    parameter int ADC_BITS = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ADC_BITS-1:0] adc_code,
    output logic                push,
    output word_t               push_word,
    input  q_stat_t             stat
);

    localparam int THR_W = ADC_BITS + 1;
    localparam logic [63:0] Q     = 64'd1 << QBITS;
    localparam logic [63:0] T0    = 64'(T0_X100);
    localparam logic [63:0] FULLS = 64'd1 << ADC_BITS;

    // Lowest code at which each whole degree is reached; unused slots never match
    logic [THR_W-1:0] thr_tab [TAB_DEPTH];

    for (genvar k = 0; k < TAB_DEPTH; k++) begin : g_thr
        if (k >= 1 && k <= TEMP_MAX) begin : g_live
            localparam logic [63:0] TK   = 64'(TK_BASE) + 64'(100 * k);
            localparam bit          WARM = TK > T0;
            localparam logic [63:0] DK   = WARM ? TK - T0 : T0 - TK;
            localparam logic [63:0] DEN  = TK * T0;
            localparam logic [63:0] YM   = ((64'(BETA_X100) * DK) << QBITS) / DEN;
            localparam logic [63:0] X    = YM >> 3;
            localparam logic [63:0] TM1  = ((Q    * X) >> QBITS) / 64'd1;
            localparam logic [63:0] TM2  = ((TM1  * X) >> QBITS) / 64'd2;
            localparam logic [63:0] TM3  = ((TM2  * X) >> QBITS) / 64'd3;
            localparam logic [63:0] TM4  = ((TM3  * X) >> QBITS) / 64'd4;
            localparam logic [63:0] TM5  = ((TM4  * X) >> QBITS) / 64'd5;
            localparam logic [63:0] TM6  = ((TM5  * X) >> QBITS) / 64'd6;
            localparam logic [63:0] TM7  = ((TM6  * X) >> QBITS) / 64'd7;
            localparam logic [63:0] TM8  = ((TM7  * X) >> QBITS) / 64'd8;
            localparam logic [63:0] TM9  = ((TM8  * X) >> QBITS) / 64'd9;
            localparam logic [63:0] TM10 = ((TM9  * X) >> QBITS) / 64'd10;
            localparam logic [63:0] TM11 = ((TM10 * X) >> QBITS) / 64'd11;
            localparam logic [63:0] TM12 = ((TM11 * X) >> QBITS) / 64'd12;
            localparam logic [63:0] TM13 = ((TM12 * X) >> QBITS) / 64'd13;
            localparam logic [63:0] TM14 = ((TM13 * X) >> QBITS) / 64'd14;
            localparam logic [63:0] S0   = Q + TM1 + TM2 + TM3 + TM4 + TM5 + TM6 + TM7
                                         + TM8 + TM9 + TM10 + TM11 + TM12 + TM13 + TM14;
            localparam logic [63:0] S1   = (S0 * S0) >> QBITS;
            localparam logic [63:0] S2   = (S1 * S1) >> QBITS;
            localparam logic [63:0] E    = (S2 * S2) >> QBITS;
            localparam logic [63:0] NUM  = WARM ? (E << ADC_BITS) : (Q << ADC_BITS);
            localparam logic [63:0] DV   = E + Q;
            localparam logic [63:0] THR  = (NUM + DV - 64'd1) / DV;
            assign thr_tab[k] = THR[THR_W-1:0];
        end
        else begin : g_pad
            assign thr_tab[k] = FULLS[THR_W-1:0];
        end
    end

    logic                code_reg [TEMP_W-1][ADC_BITS];
    temp_t               t_reg    [TEMP_W];
    logic [TEMP_W-1:0]   v_reg;
    logic                adv;

    // The search pipe moves as one; it only stops when a finished word cannot enter the queue
    assign adv       = !v_reg[TEMP_W-1] || !stat.full;
    assign in_ready  = adv;
    assign push      = v_reg[TEMP_W-1] && !stat.full;

    // One stage per temperature bit, most significant first
    for (genvar j = 0; j < TEMP_W; j++) begin : g_stage
        localparam int BITPOS = TEMP_W - 1 - j;
        logic [ADC_BITS-1:0] code_in;
        temp_t               t_in;
        logic                v_in;
        temp_t               cand;
        logic                take;

        if (j == 0) begin : g_head
            assign code_in = adc_code;
            assign t_in    = '0;
            assign v_in    = in_valid;
        end
        else begin : g_body
            for (genvar b = 0; b < ADC_BITS; b++) begin : g_cb
                assign code_in[b] = code_reg[j-1][b];
            end
            assign t_in = t_reg[j-1];
            assign v_in = v_reg[j-1];
        end

        assign cand = t_in | (temp_t'(1) << BITPOS);
        assign take = thr_tab[cand] <= {1'b0, code_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                t_reg[j] <= take ? cand : t_in;
            end
        end

        if (j < TEMP_W - 1) begin : g_hold
            for (genvar b = 0; b < ADC_BITS; b++) begin : g_hb
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        code_reg[j][b] <= code_in[b];
                    end
                end
            end
        end
    end

    // Split into digits: tens by reciprocal multiply, exact for 0..99
    logic [13:0] prod;
    digit_t      tens;
    temp_t       tens10;
    digit_t      units;

    always_comb
    begin
        prod      = {7'd0, t_reg[TEMP_W-1]} * 14'd103;
        tens      = prod[13:10];
        tens10    = temp_t'({tens, 3'b000}) + temp_t'({tens, 1'b0});
        units     = digit_t'(t_reg[TEMP_W-1] - tens10);
        push_word = {seg_tens(tens), seg_units(units)};
    end

endmodule

// ----- rtl/ntc7s_queue.sv -----
module ntc7s_queue
    import ntc7s_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  word_t   push_word,
    input  logic    pop,
    output word_t   pop_word,
    output q_stat_t stat
);

    word_t              fifo_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;

    assign stat.full  = cnt_reg == QCNT_W'(QDEPTH);
    assign stat.empty = cnt_reg == '0;
    assign pop_word   = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                cnt_reg <= QCNT_W'(cnt_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= QCNT_W'(cnt_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ----- rtl/ntc7s_back.sv -----
module ntc7s_back
    import ntc7s_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_stat_t stat,
    input  word_t   pop_word,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output logic    serial_bit,
    output logic    latch_after
);

    word_t    word_reg;
    bit_cnt_t cnt_reg;
    logic     busy_reg;
    logic     last;
    logic     xfer;

    assign last        = cnt_reg == bit_cnt_t'(WORD_BITS - 1);
    assign xfer        = busy_reg && out_ready;
    assign out_valid   = busy_reg;
    assign serial_bit  = word_reg[0];
    assign latch_after = last;

    // Take the next word as soon as the current one has gone out
    assign pop = !stat.empty && (!busy_reg || (xfer && last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (xfer && last)
            begin
                busy_reg <= 1'b0;
            end
            if (xfer)
            begin
                cnt_reg <= bit_cnt_t'(cnt_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg <= pop_word;
        end
        else if (xfer)
        begin
            word_reg <= word_reg >> 1;
        end
    end

endmodule

// ----- tb/ntc_segment_word_checker.sv -----
module ntc_segment_word_checker #(
    parameter int CODE_W = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [CODE_W-1:0] adc_code,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              serial_bit,
    input  logic              latch_after,
    output int                mismatches,
    output int                bits_pending
);

    localparam int          FRAC      = 28;
    localparam logic [63:0] UNITY     = 64'd1 << FRAC;
    localparam int          TOP_DEG   = 99;
    localparam int          WORD_LEN  = 16;

    // Active-low digit patterns, digit 9 in the top byte down to digit 0 in the bottom byte
    localparam logic [79:0] LEFT_SEGS  = {8'h21, 8'h01, 8'hF1, 8'h05, 8'h25,
                                          8'h39, 8'h61, 8'h43, 8'hF9, 8'h81};
    localparam logic [79:0] RIGHT_SEGS = {8'h48, 8'h08, 8'hF8, 8'h0A, 8'h4A,
                                          8'hC9, 8'h68, 8'h2C, 8'hF9, 8'h18};

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              seg_bit;
        logic              last_bit;
    } serial_bit_t;

    serial_bit_t        serial_bits_due[$];
    serial_bit_t        want;
    serial_bit_t        next_bit;
    logic [WORD_LEN-1:0] word;

    // Taylor series on a/8, then square three times
    function automatic logic [63:0] q28_exp(input logic [63:0] mag);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] n;
        x    = mag >> 3;
        term = UNITY;
        acc  = UNITY;
        for (n = 1; n <= 14; n = n + 1)
        begin
            term = ((term * x) >> FRAC) / n;
            acc  = acc + term;
        end
        for (n = 0; n < 3; n = n + 1)
            acc = (acc * acc) >> FRAC;
        return acc;
    endfunction

    // True when the code sits at or above the point where the curve crosses k - 0.5 C
    function automatic bit reaches_half_degree(input logic [CODE_W-1:0] code, input int k);
        logic [63:0] tk;
        logic [63:0] den;
        logic [63:0] gap;
        logic [63:0] mag;
        logic [63:0] e;
        logic [63:0] lhs;
        bit          warmer;
        tk     = 64'd27265 + 64'd100 * k;
        den    = tk * 64'd29815;
        warmer = tk > 64'd29815;
        gap    = warmer ? tk - 64'd29815 : 64'd29815 - tk;
        mag    = ((64'd395000 * gap) << FRAC) / den;
        e      = q28_exp(mag);
        lhs    = code * (e + UNITY);
        if (!warmer)
            return lhs >= (UNITY << CODE_W);
        return lhs >= (e << CODE_W);
    endfunction

    function automatic logic [WORD_LEN-1:0] segment_word(input logic [CODE_W-1:0] code);
        int deg;
        deg = 0;
        for (int k = 1; k <= TOP_DEG; k++)
            if (reaches_half_degree(code, k))
                deg++;
        return {LEFT_SEGS[(deg / 10) * 8 +: 8], RIGHT_SEGS[(deg % 10) * 8 +: 8]};
    endfunction

    // Print one line per mismatch and count it
    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mismatches   = 0;
            bits_pending = 0;
            serial_bits_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (serial_bits_due.size() == 0)
                    flag_mismatch($sformatf("bit %0b latch %0b with nothing outstanding",
                                            serial_bit, latch_after));
                else
                begin
                    want = serial_bits_due.pop_front();
                    if (serial_bit !== want.seg_bit)
                        flag_mismatch($sformatf("code %0d: serial_bit %0b, want %0b",
                                                want.code, serial_bit, want.seg_bit));
                    if (latch_after !== want.last_bit)
                        flag_mismatch($sformatf("code %0d: latch_after %0b, want %0b",
                                                want.code, latch_after, want.last_bit));
                end
            end
            if (in_valid && in_ready)
            begin
                word = segment_word(adc_code);
                for (int b = 0; b < WORD_LEN; b++)
                begin
                    next_bit.code     = adc_code;
                    next_bit.seg_bit  = word[b];
                    next_bit.last_bit = (b == WORD_LEN - 1);
                    serial_bits_due.push_back(next_bit);
                end
            end
            bits_pending = serial_bits_due.size();
        end
    end

endmodule

// ----- tb/tb_ntc_temperature_to_seven_segment.sv -----
module tb_ntc_temperature_to_seven_segment;

    localparam int CODE_W       = 10;
    localparam int HALF_PERIOD  = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int RX_HOLD      = 300;
    localparam int RANDOM_CODES = 100;
    localparam int IDLE_PCT     = 18;
    localparam int SETTLE       = 30;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [CODE_W-1:0] adc_code;
    logic              out_valid;
    logic              out_ready;
    logic              serial_bit;
    logic              latch_after;

    int mismatches;
    int bits_pending;
    int stall_cycles = 0;
    bit quiet;
    bit rx_hold;

    int corner_codes[$] = '{0, 1023, 3, 100, 300, 511, 700, 850, 930, 970, 1000, 1022};

    always #(HALF_PERIOD) clk = ~clk;

    ntc_temperature_to_seven_segment #(
        .ADC_BITS (CODE_W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .adc_code    (adc_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .serial_bit  (serial_bit),
        .latch_after (latch_after)
    );

    ntc_segment_word_checker #(
        .CODE_W (CODE_W)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .adc_code     (adc_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .serial_bit   (serial_bit),
        .latch_after  (latch_after),
        .mismatches   (mismatches),
        .bits_pending (bits_pending)
    );

    // Present one code and hold it until the transfer
    task automatic offer_code(input logic [CODE_W-1:0] code);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid = 1'b1;
        adc_code = code;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain_serial_bits();
        in_valid = 1'b0;
        while (bits_pending != 0)
            @(negedge clk);
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                out_ready = 1'b0;
                repeat (RX_HOLD) @(negedge clk);
                rx_hold = 1'b0;
            end
            out_ready = quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        logic [CODE_W-1:0] code;
        in_valid  = 1'b0;
        adc_code  = '0;
        out_ready = 1'b0;
        rst_n     = 1'b0;
        quiet     = 1'b0;
        rx_hold   = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk a single one across the code, then the ends and points in between
        for (int b = 0; b < CODE_W; b++)
            offer_code(CODE_W'(1 << b));
        foreach (corner_codes[i])
            offer_code(CODE_W'(corner_codes[i]));
        drain_serial_bits();

        for (int n = 0; n < RANDOM_CODES; n++)
        begin
            if (n == 20)
                rx_hold = 1'b1;
            if (n == 45)
                drain_serial_bits();
            quiet = (n >= 50 && n < 80);
            // Bias part of the traffic to the hot end, where the digits change fastest
            if ($urandom_range(0, 9) < 7)
                code = CODE_W'($urandom_range(0, 1023));
            else
                code = CODE_W'($urandom_range(880, 1023));
            offer_code(code);
        end
        drain_serial_bits();
        repeat (SETTLE) @(negedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
